FILE: sv/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants for the keyed LRU cache.
// ----------------------------------------------------------------------------
package lkc_pkg;
	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_EVICT  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [31:0] payload;
	} req_t;

	typedef struct packed {
		logic [31:0] eviction_total;
		logic [31:0] miss_total;
		logic [31:0] hit_total;
		logic [8:0]  occupancy;
		logic [31:0] evicted_payload;
		logic [31:0] evicted_key;
		logic        evicted;
		logic        inserted;
		logic [31:0] found_payload;
		logic        hit;
	} rsp_t;
endpackage

FILE: sv/lkc_front.sv
// ----------------------------------------------------------------------------
// lkc_front
// Accepts request words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lkc_front import lkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_req,
	output logic        q_valid,
	input  logic        q_pop,
	output req_t        q_req
);
	req_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !(q_pop && q_valid))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> cnt_q == 2'd2)
		else $error("full queue lost a word");
endmodule

FILE: sv/lkc_back.sv
// ----------------------------------------------------------------------------
// lkc_back
// Executes requests: scans the store one entry a cycle for a key match,
// the oldest stamp and the first free slot, then writes back.
// ----------------------------------------------------------------------------
module lkc_back import lkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [8:0]  capacity,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_EVRD  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [31:0] key_mem [DEPTH];
	logic [31:0] pay_mem [DEPTH];
	logic [63:0] stp_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [2:0]  state_q;
	req_t        req_q;
	logic [CNT_W-1:0] idx_q;
	logic        rd_v_s1;
	logic [IDX_W-1:0] rd_i_s1;
	logic [31:0] rk_s1, rp_s1;
	logic [63:0] rs_s1;

	logic        mfound_q, ofound_q, ffound_q;
	logic [IDX_W-1:0] midx_q, oidx_q, fidx_q;
	logic [63:0] ostamp_q;
	logic [31:0] mpay_q;

	logic [63:0] clock_q;
	logic [8:0]  total_q;
	logic [31:0] hits_q, miss_q, evs_q;
	logic        out_v_q;
	rsp_t        rsp_q;

	logic [8:0]  cap_eff;
	logic        is_lu, need_ev;
	logic        fire;

	assign cap_eff = (capacity > 9'(DEPTH)) ? 9'(DEPTH) : capacity;
	assign is_lu   = (req_q.kind == KIND_LOOKUP) || (req_q.kind == KIND_INSERT);
	assign need_ev = (req_q.kind == KIND_EVICT) ||
		(req_q.kind == KIND_INSERT && !mfound_q && total_q >= cap_eff);
	assign fire      = (state_q == ST_WRITE) && (!out_v_q || rsp_ready);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign rsp_valid = out_v_q;
	assign rsp       = rsp_q;

	logic             we;
	logic [IDX_W-1:0] wa;
	logic [31:0]      wk, wp;
	logic [63:0]      ws;
	logic             wkp;

	always_comb begin
		we  = 1'b0;
		wkp = 1'b0;
		wa  = midx_q;
		wk  = req_q.key;
		wp  = req_q.payload;
		ws  = clock_q;
		if (fire && is_lu) begin
			if (mfound_q) begin
				we = 1'b1;
			end else if (req_q.kind == KIND_INSERT) begin
				we  = 1'b1;
				wkp = 1'b1;
				wa  = (need_ev && ofound_q && !ffound_q) ? oidx_q :
					((need_ev && ofound_q && oidx_q < fidx_q) ? oidx_q : fidx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stp_mem[wa] <= ws;
			if (wkp) begin
				key_mem[wa] <= wk;
				pay_mem[wa] <= wp;
			end
		end
		rk_s1 <= key_mem[idx_q[IDX_W-1:0]];
		rp_s1 <= pay_mem[idx_q[IDX_W-1:0]];
		rs_s1 <= stp_mem[idx_q[IDX_W-1:0]];
		rd_i_s1 <= idx_q[IDX_W-1:0];
		if (state_q == ST_IDLE && q_valid) req_q <= q_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			mfound_q <= 1'b0;
			ofound_q <= 1'b0;
			ffound_q <= 1'b0;
			midx_q   <= '0;
			oidx_q   <= '0;
			fidx_q   <= '0;
			ostamp_q <= '0;
			mpay_q   <= '0;
			clock_q  <= '0;
			total_q  <= '0;
			hits_q   <= '0;
			miss_q   <= '0;
			evs_q    <= '0;
			out_v_q  <= 1'b0;
			rsp_q    <= '0;
		end else begin
			out_v_q <= fire || (out_v_q && !rsp_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q  <= ST_SCAN;
						idx_q    <= '0;
						rd_v_s1  <= 1'b0;
						mfound_q <= 1'b0;
						ofound_q <= 1'b0;
						ffound_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_v_s1 <= (idx_q < CNT_W'(DEPTH));
					if (idx_q < CNT_W'(DEPTH)) idx_q <= idx_q + 1'b1;
					if (rd_v_s1) begin
						if (valid_q[rd_i_s1]) begin
							if (!mfound_q && rk_s1 == req_q.key) begin
								mfound_q <= 1'b1;
								midx_q   <= rd_i_s1;
								mpay_q   <= rp_s1;
							end
							if (!ofound_q || rs_s1 < ostamp_q) begin
								ofound_q <= 1'b1;
								oidx_q   <= rd_i_s1;
								ostamp_q <= rs_s1;
							end
						end else if (!ffound_q) begin
							ffound_q <= 1'b1;
							fidx_q   <= rd_i_s1;
						end
					end
					if (!rd_v_s1 && idx_q == CNT_W'(DEPTH)) begin
						state_q <= ST_EVRD;
						idx_q   <= CNT_W'(oidx_q);
					end
				end
				ST_EVRD: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (fire) begin
						logic [8:0]       tot;
						logic             ev;
						logic [DEPTH-1:0] vn;
						rsp_t             r;
						tot = total_q;
						ev  = 1'b0;
						vn  = valid_q;
						r   = '0;
						r.hit_total  = hits_q;
						r.miss_total = miss_q;
						if (is_lu) begin
							if (mfound_q) begin
								hits_q  <= hits_q + 1'b1;
								clock_q <= clock_q + 1'b1;
								r.hit = 1'b1;
								r.found_payload = mpay_q;
								r.hit_total = hits_q + 1'b1;
							end else begin
								miss_q <= miss_q + 1'b1;
								r.miss_total = miss_q + 1'b1;
							end
						end
						if (need_ev && ofound_q) begin
							ev = 1'b1;
							vn[oidx_q] = 1'b0;
							tot = tot - 1'b1;
							r.evicted = 1'b1;
							r.evicted_key = rk_s1;
							r.evicted_payload = rp_s1;
						end
						if (req_q.kind == KIND_INSERT && !mfound_q) begin
							vn[wa] = 1'b1;
							tot = tot + 1'b1;
							clock_q <= clock_q + 1'b1;
							r.inserted = 1'b1;
						end
						if (req_q.kind == KIND_REMOVE && mfound_q) begin
							vn[midx_q] = 1'b0;
							tot = tot - 1'b1;
							r.hit = 1'b1;
							r.found_payload = mpay_q;
						end
						if (req_q.kind == KIND_CLEAR) begin
							vn = '0;
							tot = '0;
						end
						evs_q <= evs_q + 32'(ev);
						r.eviction_total = evs_q + 32'(ev);
						r.occupancy = tot;
						valid_q <= vn;
						total_q <= tot;
						rsp_q   <= r;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= 9'(DEPTH))
		else $error("occupancy above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp_ready) |=> $stable(rsp_q))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && we && wkp) |-> !valid_q[wa] || (need_ev && wa == oidx_q))
		else $error("insert over a live entry");
endmodule

FILE: sv/lru_keyed_cache.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache
// Fully associative keyed store of handles with least-recently-used eviction.
// ----------------------------------------------------------------------------
// channel   dir  word
// s_axis    in   tdata {payload, key}, tuser kind
// m_axis    out  tdata result fields
// capacity  in   write enable + 9-bit data
// Each word is handled with one store read per cycle in the scan, then an
// eviction read and the write-back. Reset clears valid bits at once.
// A two-word queue lets requests arrive while a result waits on m_axis_tready.
module lru_keyed_cache import lkc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // key, payload
	input  logic [2:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [239:0] m_axis_tdata   // hit, found_payload, inserted, evicted,
	                                     // evicted_key, evicted_payload,
	                                     // occupancy, hit_total, miss_total,
	                                     // eviction_total, zero fill
);
	logic [8:0] capacity_q;
	logic       q_valid, q_pop;
	req_t       in_req, q_req;
	rsp_t       rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= 9'd256;
		else if (cfg_we) capacity_q <= cfg_wdata;
	end

	assign in_req.kind    = s_axis_tuser;
	assign in_req.key     = s_axis_tdata[31:0];
	assign in_req.payload = s_axis_tdata[63:32];
	assign m_axis_tdata   = {36'd0, rsp};

	lkc_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
		.q_valid, .q_pop, .q_req
	);

	lkc_back u_back (
		.clk, .arst_n, .capacity(capacity_q),
		.q_valid, .q_pop, .q_req,
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp
	);
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed LRU cache. Requests go in on s_axis and
// every request returns one result word on m_axis. A behavioral copy of the
// store predicts each result, and the checker compares it field by field.
// Directed cases cover the corner behaviors, then random phases sweep the
// capacity register under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import lkc_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [8:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;   // key, payload
	logic [2:0]   s_axis_tuser;   // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [239:0] m_axis_tdata;   // result fields, hit first

	lru_keyed_cache dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// behavioral copy of the store
	logic        slot_valid [DEPTH];
	logic [31:0] slot_key [DEPTH];
	logic [31:0] slot_handle [DEPTH];
	logic [63:0] slot_stamp [DEPTH];
	logic [63:0] use_count;
	logic [8:0]  live_entries;
	logic [31:0] hits_run, misses_run, evicts_run;
	logic [8:0]  cap_reg;

	rsp_t pending_results[$];
	int   errors = 0;
	int   words_sent = 0;
	int   words_checked = 0;
	int   send_gap_pct = 0;
	int   stall_pct = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Timeout at %0t", $time);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void clear_model();
		for (int i = 0; i < DEPTH; i++) slot_valid[i] = 0;
		live_entries = 0;
	endfunction

	function automatic int oldest_slot();
		int best;
		best = -1;
		for (int i = 0; i < DEPTH; i++)
			if (slot_valid[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) best = i;
		return best;
	endfunction

	function automatic rsp_t predict_result(logic [2:0] kind, logic [31:0] key,
			logic [31:0] handle);
		rsp_t r;
		int   idx;
		int   eff_cap;
		r = '0;
		idx = -1;
		eff_cap = (cap_reg < DEPTH) ? cap_reg : DEPTH;
		if (kind == KIND_LOOKUP || kind == KIND_INSERT || kind == KIND_REMOVE)
			for (int i = 0; i < DEPTH; i++)
				if (idx < 0 && slot_valid[i] && slot_key[i] == key) idx = i;
		if (kind == KIND_LOOKUP || kind == KIND_INSERT) begin
			if (idx >= 0) begin
				slot_stamp[idx] = use_count;
				use_count++;
				hits_run++;
				r.hit = 1;
				r.found_payload = slot_handle[idx];
			end else begin
				misses_run++;
				if (kind == KIND_INSERT) begin
					if (live_entries >= eff_cap) begin
						idx = oldest_slot();
						if (idx >= 0) begin
							r.evicted = 1;
							r.evicted_key = slot_key[idx];
							r.evicted_payload = slot_handle[idx];
							slot_valid[idx] = 0;
							live_entries--;
							evicts_run++;
						end
					end
					idx = -1;
					for (int i = 0; i < DEPTH; i++)
						if (idx < 0 && !slot_valid[i]) idx = i;
					if (idx >= 0) begin
						slot_valid[idx] = 1;
						slot_key[idx] = key;
						slot_handle[idx] = handle;
						slot_stamp[idx] = use_count;
						use_count++;
						live_entries++;
						r.inserted = 1;
					end
				end
			end
		end else if (kind == KIND_REMOVE) begin
			if (idx >= 0) begin
				r.hit = 1;
				r.found_payload = slot_handle[idx];
				slot_valid[idx] = 0;
				live_entries--;
			end
		end else if (kind == KIND_CLEAR) begin
			clear_model();
		end else if (kind == KIND_EVICT) begin
			idx = oldest_slot();
			if (idx >= 0) begin
				r.evicted = 1;
				r.evicted_key = slot_key[idx];
				r.evicted_payload = slot_handle[idx];
				slot_valid[idx] = 0;
				live_entries--;
				evicts_run++;
			end
		end
		r.occupancy = live_entries;
		r.hit_total = hits_run;
		r.miss_total = misses_run;
		r.eviction_total = evicts_run;
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(logic [2:0] kind, logic [31:0] key, logic [31:0] handle);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {handle, key};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict_result(kind, key, handle));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DEPTH + 20) @(negedge clk);
	endtask

	task automatic write_capacity(logic [8:0] value);
		drain();
		cfg_we <= 1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 0;
		cap_reg = value;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always_ff @(negedge clk)
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = rsp_t'(m_axis_tdata[203:0]);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %h", $time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				check_field("hit", want.hit, got.hit);
				check_field("found_payload", want.found_payload, got.found_payload);
				check_field("inserted", want.inserted, got.inserted);
				check_field("evicted", want.evicted, got.evicted);
				check_field("evicted_key", want.evicted_key, got.evicted_key);
				check_field("evicted_payload", want.evicted_payload, got.evicted_payload);
				check_field("occupancy", want.occupancy, got.occupancy);
				check_field("hit_total", want.hit_total, got.hit_total);
				check_field("miss_total", want.miss_total, got.miss_total);
				check_field("eviction_total", want.eviction_total, got.eviction_total);
				if (m_axis_tdata[239:204] !== '0) begin
					errors++;
					$display("%0t: fill bits expected 0, actual %h", $time,
						m_axis_tdata[239:204]);
				end
			end
		end
	end

	task automatic test_basic_ops();
		send_word(KIND_LOOKUP, 32'h0, 32'h0);
		send_word(KIND_EVICT, 32'h0, 32'h0);
		send_word(KIND_INSERT, 32'h0, 32'h0);
		send_word(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(KIND_LOOKUP, 32'h0, 32'h1234_5678);
		send_word(KIND_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555);
		send_word(KIND_INSERT, 32'h5555_AAAA, 32'h8000_0001);
		send_word(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_word(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_word(KIND_EVICT, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
		send_word(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(3'd6, 32'h0, 32'h0);
		send_word(3'd7, 32'h1, 32'h2);
		send_word(KIND_CLEAR, 32'hFFFF_FFFF, 32'h0);
		send_word(KIND_EVICT, 32'h0, 32'h0);
		send_word(KIND_LOOKUP, 32'h5555_AAAA, 32'h0);
	endtask

	task automatic test_capacity_edges();
		write_capacity(9'd1);
		send_word(KIND_INSERT, 32'h10, 32'h100);
		send_word(KIND_INSERT, 32'h11, 32'h101);
		write_capacity(9'd0);
		send_word(KIND_INSERT, 32'h12, 32'h102);
		send_word(KIND_INSERT, 32'h13, 32'h103);
		write_capacity(9'd511);
		send_word(KIND_INSERT, 32'h14, 32'h104);
		send_word(KIND_LOOKUP, 32'h13, 32'h0);
		send_word(KIND_CLEAR, 32'h0, 32'h0);
	endtask

	task automatic test_random_phase(logic [8:0] cap, int count, int key_pool, int mode);
		logic [2:0]  kind;
		logic [31:0] key;
		int          roll;
		write_capacity(cap);
		send_gap_pct = (mode == 1) ? 47 : (mode == 3) ? 14 : 0;
		stall_pct = (mode == 2) ? 47 : (mode == 3) ? 14 : 0;
		repeat (count) begin
			roll = $urandom_range(99);
			kind = roll < 32 ? KIND_LOOKUP : roll < 75 ? KIND_INSERT : roll < 86 ? KIND_REMOVE :
				roll < 88 ? KIND_CLEAR : roll < 95 ? KIND_EVICT : 3'($urandom_range(7, 5));
			key = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(key_pool - 1);
			send_word(kind, key, $urandom());
		end
		send_gap_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 0;
		cap_reg = 9'd256;
		use_count = '0;
		hits_run = '0;
		misses_run = '0;
		evicts_run = '0;
		clear_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_basic_ops();
		test_capacity_edges();
		test_random_phase(9'd4, 180, 12, 0);
		test_random_phase(9'd1, 120, 4, 1);
		test_random_phase(9'd0, 100, 4, 2);
		test_random_phase(9'd17, 200, 40, 3);
		test_random_phase(9'd256, 420, 600, 0);
		test_random_phase(9'd9, 150, 30, 2);
		test_random_phase(9'd300, 200, 120, 1);
		test_random_phase(9'd255, 180, 80, 3);
		drain();

		$display("Sent %0d request words, checked %0d results, capacities 0 to 511",
			words_sent, words_checked);
		$display("under no idling, sender gaps, receiver stalls and both mixed");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors, %0d results missing", errors, pending_results.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/lkc_pkg.sv
sv/lkc_front.sv
sv/lkc_back.sv
sv/lru_keyed_cache.sv
bench/tb_top.sv
